// File: hdl/fetc_pkg.sv
// Shared constants, types and helpers for the fuel economy trip computer.
package fetc_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int WIN_IDX_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int RATE_W       = 16;
  localparam int FPM_W        = 26;
  localparam int RSUM_W       = RATE_W + FILL_W;
  localparam int FSUM_W       = FPM_W + FILL_W;
  localparam int DIV_W        = 64;
  localparam int DIV_CNT_W    = $clog2(DIV_W + 1);

  localparam logic [FPM_W-1:0] FPM_MAX   = '1;
  localparam logic [16:0]      SPEED_MAX = '1;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Window update request from the sequencer.
  typedef struct packed {
    logic             en;
    logic [RATE_W-1:0] rate;
    logic [FPM_W-1:0]  fpm;
    logic             ok;
  } win_upd_t;

  // Running window sums seen by the sequencer.
  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic [RSUM_W-1:0] rate_sum;
    logic [FSUM_W-1:0] fpm_sum;
    logic [FILL_W-1:0] fpm_count;
  } win_stat_t;

  // x * 4608 = x * 4096 + x * 512, kept to 64 bits.
  function automatic logic [DIV_W-1:0] mul4608(input logic [DIV_W-1:0] x);
    mul4608 = (x << 12) + (x << 9);
  endfunction

  // x * 5 = x * 4 + x, kept to 64 bits.
  function automatic logic [DIV_W-1:0] mul5(input logic [DIV_W-1:0] x);
    mul5 = (x << 2) + x;
  endfunction

endpackage

// File: hdl/fetc_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module fetc_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [fetc_pkg::DIV_W-1:0] num,
  input  logic [fetc_pkg::DIV_W-1:0] den,
  output logic                     done,
  output logic [fetc_pkg::DIV_W-1:0] quo
);
  import fetc_pkg::*;

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_W:0]       shifted;
  logic                 fits;

  assign shifted = {rem, quo[DIV_W-1]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      quo     <= num;
      divisor <= den;
    end else if (busy) begin
      rem <= fits ? DIV_W'(shifted - {1'b0, divisor}) : shifted[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

endmodule

// File: hdl/fetc_window.sv
// Sliding window of flow rates and flow per metre values with running sums.
module fetc_window (
  input  logic                clk,
  input  logic                rst,
  input  fetc_pkg::win_upd_t  upd,
  output fetc_pkg::win_stat_t stat
);
  import fetc_pkg::*;

  logic [RATE_W-1:0]    rate_mem [WINDOW_DEPTH];
  logic [FPM_W-1:0]     fpm_mem  [WINDOW_DEPTH];
  logic                 ok_mem   [WINDOW_DEPTH];
  logic [WIN_IDX_W-1:0] head;
  logic                 full;

  assign full = stat.fill == FILL_W'(WINDOW_DEPTH);

  always_ff @(posedge clk) begin
    if (upd.en) begin
      rate_mem[head] <= upd.rate;
      fpm_mem[head]  <= upd.fpm;
      ok_mem[head]   <= upd.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head           <= '0;
      stat.fill      <= '0;
      stat.rate_sum  <= '0;
      stat.fpm_sum   <= '0;
      stat.fpm_count <= '0;
    end else if (upd.en) begin
      // The oldest entry sits at the head once the window is full.
      if (full) begin
        stat.rate_sum <= stat.rate_sum - RSUM_W'(rate_mem[head]) + RSUM_W'(upd.rate);
        stat.fpm_sum  <= stat.fpm_sum
                         - (ok_mem[head] ? FSUM_W'(fpm_mem[head]) : '0)
                         + (upd.ok ? FSUM_W'(upd.fpm) : '0);
        stat.fpm_count <= stat.fpm_count - FILL_W'(ok_mem[head]) + FILL_W'(upd.ok);
      end else begin
        stat.fill      <= stat.fill + 1'b1;
        stat.rate_sum  <= stat.rate_sum + RSUM_W'(upd.rate);
        stat.fpm_sum   <= stat.fpm_sum + (upd.ok ? FSUM_W'(upd.fpm) : '0);
        stat.fpm_count <= stat.fpm_count + FILL_W'(upd.ok);
      end
      head <= (head == WIN_IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head + 1'b1;
    end
  end

endmodule

// File: hdl/fuel_economy_trip_computer.sv
// Top level of the fuel economy trip computer: sequencer, totals and result register.
//
//   channel | direction | contents
//   s_*     | in        | tuser = req_type; tdata = flow_rate, speed_kmh, interval_ms
//   m_*     | out       | tdata = all ten result fields, one transaction per input
//
// Each transaction runs through up to five divisions on one shared 64-bit
// restoring divider. A division step launches the divider, waits for its
// quotient bits and then takes the quotient. Steps whose divisor is zero
// are skipped. The divider sets the pace.
// rst is synchronous and clears the window sums, the totals and the sequencer.
// s_tready is high only while the sequencer is idle. A finished result waits
// in the output register; the next transaction may be accepted meanwhile and
// its result is held back until the previous one has been taken.
module fuel_economy_trip_computer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // flow_rate[15:0], speed_kmh[24:16], interval_ms[40:25]
  input  logic         s_tuser,   // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [223:0] m_tdata    // mean_flow_rate, mean_flow_per_metre, mean_fpm_valid,
                                  // fuel_total, distance_total, time_total,
                                  // trip_flow_per_metre, trip_fpm_valid,
                                  // mean_speed, mean_speed_valid
);
  import fetc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_FPM    = 8'b0000_0010,
    S_UPDATE = 8'b0000_0100,
    S_MRATE  = 8'b0000_1000,
    S_MFPM   = 8'b0001_0000,
    S_TRIP   = 8'b0010_0000,
    S_SPEED  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;

  // Latched sample fields.
  logic [15:0] flow;
  logic [8:0]  speed;
  logic [15:0] interval;

  // Trip totals, saturating.
  logic [47:0] fuel_acc;
  logic [47:0] distance_acc;
  logic [39:0] time_acc;

  // Working results.
  logic [FPM_W-1:0] sample_fpm;
  logic [15:0]      mean_rate;
  logic [FPM_W-1:0] mean_fpm;
  logic [FPM_W-1:0] trip_fpm;
  logic [16:0]      mean_spd;

  logic             launched;
  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] div_num;
  logic [DIV_W-1:0] div_den;
  logic [DIV_W-1:0] div_quo;
  logic             skip;

  win_upd_t  upd;
  win_stat_t stat;

  logic [48:0] fuel_sum;
  logic [48:0] dist_sum;
  logic [40:0] time_sum;

  fetc_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  fetc_window u_win (
    .clk  (clk),
    .rst  (rst),
    .upd  (upd),
    .stat (stat)
  );

  assign s_tready = state == S_IDLE;

  assign upd.en   = state == S_UPDATE;
  assign upd.rate = flow;
  assign upd.fpm  = sample_fpm;
  assign upd.ok   = speed != '0;

  assign fuel_sum = {1'b0, fuel_acc} + 49'(flow * interval);
  assign dist_sum = {1'b0, distance_acc} + 49'(speed * interval);
  assign time_sum = {1'b0, time_acc} + 41'(interval);

  // Operand selection for the shared divider.
  always_comb begin
    div_num = '0;
    div_den = '0;
    case (state)
      S_FPM: begin
        div_num = mul4608(DIV_W'(flow));
        div_den = mul5(DIV_W'(speed));
      end
      S_MRATE: begin
        div_num = DIV_W'(stat.rate_sum);
        div_den = DIV_W'(stat.fill);
      end
      S_MFPM: begin
        div_num = DIV_W'(stat.fpm_sum);
        div_den = DIV_W'(stat.fpm_count);
      end
      S_TRIP: begin
        div_num = mul4608(DIV_W'(fuel_acc));
        div_den = mul5(DIV_W'(distance_acc));
      end
      S_SPEED: begin
        div_num = DIV_W'(distance_acc) << 8;
        div_den = DIV_W'(time_acc);
      end
      default: ;
    endcase
  end

  // A zero divisor means the field is invalid and reads as zero.
  assign skip      = div_den == '0;
  assign div_start = (state inside {S_FPM, S_MRATE, S_MFPM, S_TRIP, S_SPEED})
                     && !launched && !skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      launched     <= 1'b0;
      m_tvalid     <= 1'b0;
      fuel_acc     <= '0;
      distance_acc <= '0;
      time_acc     <= '0;
    end else begin
      // A new result enters as soon as the output register is free or being taken.
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (div_start) begin
        launched <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == REQ_CLEAR) begin
              fuel_acc     <= '0;
              distance_acc <= '0;
              time_acc     <= '0;
              state        <= S_MRATE;
            end else begin
              state <= S_FPM;
            end
          end
        end
        S_FPM: begin
          if (skip || div_done) begin
            launched <= 1'b0;
            state    <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          fuel_acc     <= fuel_sum[48]     ? '1 : fuel_sum[47:0];
          distance_acc <= dist_sum[48]     ? '1 : dist_sum[47:0];
          time_acc     <= time_sum[40]     ? '1 : time_sum[39:0];
          state        <= S_MRATE;
        end
        S_MRATE: begin
          if (skip || div_done) begin
            launched <= 1'b0;
            state    <= S_MFPM;
          end
        end
        S_MFPM: begin
          if (skip || div_done) begin
            launched <= 1'b0;
            state    <= S_TRIP;
          end
        end
        S_TRIP: begin
          if (skip || div_done) begin
            launched <= 1'b0;
            state    <= S_SPEED;
          end
        end
        S_SPEED: begin
          if (skip || div_done) begin
            launched <= 1'b0;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      flow     <= s_tdata[15:0];
      speed    <= s_tdata[24:16];
      interval <= s_tdata[40:25];
    end
    if (skip || div_done) begin
      case (state)
        S_FPM:   sample_fpm <= skip ? '0 :
                   ((div_quo > DIV_W'(FPM_MAX)) ? FPM_MAX : div_quo[FPM_W-1:0]);
        S_MRATE: mean_rate  <= skip ? '0 : div_quo[15:0];
        S_MFPM:  mean_fpm   <= skip ? '0 :
                   ((div_quo > DIV_W'(FPM_MAX)) ? FPM_MAX : div_quo[FPM_W-1:0]);
        S_TRIP:  trip_fpm   <= skip ? '0 :
                   ((div_quo > DIV_W'(FPM_MAX)) ? FPM_MAX : div_quo[FPM_W-1:0]);
        S_SPEED: mean_spd   <= skip ? '0 :
                   ((div_quo > DIV_W'(SPEED_MAX)) ? SPEED_MAX : div_quo[16:0]);
        default: ;
      endcase
    end
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {time_acc != '0, mean_spd,
                  distance_acc != '0, trip_fpm,
                  time_acc, distance_acc, fuel_acc,
                  stat.fpm_count != '0, mean_fpm,
                  mean_rate};
    end
  end

endmodule

// File: bench/fuel_economy_trip_computer_tb.sv
// Self-checking testbench for the fuel economy trip computer.
`timescale 1ns / 1ps

module fuel_economy_trip_computer_tb;
  import fetc_pkg::*;

  localparam int EXP_DEPTH = 64;
  localparam int DIR_ROWS = 24;
  localparam logic [47:0] MAX48 = '1;
  localparam logic [39:0] MAX40 = '1;
  localparam logic [25:0] MAX26 = '1;
  localparam logic [16:0] MAX17 = '1;

  // Idle phases of the random part.
  typedef enum int {PH_NONE, PH_SRC, PH_SNK, PH_BOTH} idle_phase_t;

  typedef struct packed {
    logic        mean_speed_valid;
    logic [16:0] mean_speed;
    logic        trip_fpm_valid;
    logic [25:0] trip_fpm;
    logic [39:0] time_total;
    logic [47:0] distance_total;
    logic [47:0] fuel_total;
    logic        mean_fpm_valid;
    logic [25:0] mean_fpm;
    logic [15:0] mean_rate;
  } trip_result_t;

  // One row of the directed table; chk selects whether exp is compared directly.
  typedef struct {
    logic        req;
    logic [15:0] rate;
    logic [8:0]  spd;
    logic [15:0] ms;
    bit          chk;
    trip_result_t exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [223:0] m_tdata;

  fuel_economy_trip_computer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: the two sliding windows and the saturating trip totals.
  logic [15:0] rate_win [WINDOW_DEPTH];
  logic [25:0] fpm_win  [WINDOW_DEPTH];
  logic        fpm_ok   [WINDOW_DEPTH];
  int unsigned win_fill, win_head;
  logic [63:0] rate_sum_m, fpm_sum_m;
  int unsigned fpm_cnt_m;
  logic [47:0] fuel_m, dist_m;
  logic [39:0] time_m;

  // Outstanding expectations, oldest at exp_rd.
  trip_result_t exp_fifo [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  int src_idle_pct = 0;   // chance of an idle cycle on the input side
  int snk_idle_pct = 0;   // chance of a stall cycle on the output side
  bit snk_hold = 1'b0;    // long receiver hold-off request
  int hold_cycles = 0;

  function automatic logic [63:0] sat_val(logic [63:0] v, logic [63:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  // Advance the predictor by one transaction and return the expected result.
  function automatic trip_result_t trip_predict(logic req, logic [15:0] rate,
                                                logic [8:0] spd, logic [15:0] ms);
    trip_result_t r;
    logic [63:0] fpm, s;
    int unsigned h;
    if (req == REQ_CLEAR) begin
      fuel_m = '0; dist_m = '0; time_m = '0;
    end else begin
      h = win_head;
      fpm = 0;
      if (spd != 0) fpm = sat_val((64'(rate) * 4608) / (64'(spd) * 5), 64'(MAX26));
      if (win_fill >= WINDOW_DEPTH) begin
        rate_sum_m -= rate_win[h];
        if (fpm_ok[h]) begin
          fpm_sum_m -= fpm_win[h];
          fpm_cnt_m--;
        end
      end else begin
        win_fill++;
      end
      rate_win[h] = rate;
      fpm_win[h] = fpm[25:0];
      fpm_ok[h] = (spd != 0);
      rate_sum_m += rate;
      if (spd != 0) begin
        fpm_sum_m += fpm;
        fpm_cnt_m++;
      end
      win_head = (h + 1 >= WINDOW_DEPTH) ? 0 : h + 1;
      s = 64'(fuel_m) + 64'(rate) * ms;
      fuel_m = 48'(sat_val(s, 64'(MAX48)));
      s = 64'(dist_m) + 64'(spd) * ms;
      dist_m = 48'(sat_val(s, 64'(MAX48)));
      s = 64'(time_m) + ms;
      time_m = 40'(sat_val(s, 64'(MAX40)));
    end
    r = '0;
    if (win_fill != 0) r.mean_rate = 16'(rate_sum_m / win_fill);
    if (fpm_cnt_m != 0) begin
      r.mean_fpm = 26'(sat_val(fpm_sum_m / fpm_cnt_m, 64'(MAX26)));
      r.mean_fpm_valid = 1'b1;
    end
    r.fuel_total = fuel_m;
    r.distance_total = dist_m;
    r.time_total = time_m;
    // Fuel times 4608 needs up to 61 bits; five times distance fits 51 bits.
    if (dist_m != 0) begin
      r.trip_fpm = 26'(sat_val((64'(fuel_m) * 4608) / (64'(dist_m) * 5), 64'(MAX26)));
      r.trip_fpm_valid = 1'b1;
    end
    if (time_m != 0) begin
      r.mean_speed = 17'(sat_val((64'(dist_m) << 8) / time_m, 64'(MAX17)));
      r.mean_speed_valid = 1'b1;
    end
    return r;
  endfunction

  // Offer one transaction and hold it until the block accepts it. The valid
  // stays high afterwards so that transactions can follow back to back.
  task automatic send_item(logic req, logic [15:0] rate, logic [8:0] spd, logic [15:0] ms);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {7'd0, ms, spd, rate};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    exp_fifo[exp_wr % EXP_DEPTH] = trip_predict(req, rate, spd, ms);
    exp_wr++;
  endtask

  // Random stimulus: mostly plausible driving, with some extremes and clears.
  task automatic send_random();
    logic [15:0] rate, ms;
    logic [8:0] spd;
    logic req;
    int k;
    k = $urandom_range(99);
    req = (k < 4) ? REQ_CLEAR : REQ_SAMPLE;
    rate = 16'($urandom);
    spd = 9'($urandom);
    ms = 16'($urandom);
    if (k < 60) begin
      spd = 9'($urandom_range(0, 160));
      ms = 16'($urandom_range(0, 250));
    end else if (k < 70) begin
      spd = 0;
    end else if (k < 75) begin
      rate = 16'hFFFF; spd = 1; ms = 16'hFFFF;
    end
    send_item(req, rate, spd, ms);
  endtask

  // Sink side: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (snk_hold && hold_cycles < 2000) begin
      hold_cycles <= hold_cycles + 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct);
    end
  end

  // Compare each accepted result with the oldest outstanding expectation.
  always @(posedge clk) begin
    trip_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (exp_wr == exp_rd) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction: %h", got);
      end else begin
        want = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: rate %h/%h fpm %h/%h v%b/%b", want.mean_rate, got.mean_rate,
                     want.mean_fpm, got.mean_fpm, want.mean_fpm_valid, got.mean_fpm_valid);
            $display("  fuel %h/%h dist %h/%h time %h/%h", want.fuel_total, got.fuel_total,
                     want.distance_total, got.distance_total, want.time_total, got.time_total);
            $display("  trip %h/%h v%b/%b speed %h/%h v%b/%b", want.trip_fpm, got.trip_fpm,
                     want.trip_fpm_valid, got.trip_fpm_valid, want.mean_speed,
                     got.mean_speed, want.mean_speed_valid, got.mean_speed_valid);
          end
        end
      end
    end
  end

  function automatic trip_result_t known_result(logic [15:0] mr, logic [25:0] mf, logic mv,
                                                logic [47:0] f, logic [47:0] d,
                                                logic [39:0] t);
    trip_result_t r;
    r = '0;
    r.mean_rate = mr; r.mean_fpm = mf; r.mean_fpm_valid = mv;
    r.fuel_total = f; r.distance_total = d; r.time_total = t;
    return r;
  endfunction

  dir_row_t directed [DIR_ROWS];

  // Stop offering and wait until every expected result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    dir_row_t row;
    trip_result_t got_exp;
    idle_phase_t ph;
    win_fill = 0; win_head = 0; rate_sum_m = 0; fpm_sum_m = 0; fpm_cnt_m = 0;
    fuel_m = 0; dist_m = 0; time_m = 0;

    // Directed table. The first rows are after reset with zero totals and read
    // off directly; the rest go through the predictor.
    directed[0] = '{REQ_CLEAR, 16'h0, 9'd0, 16'h0, 1'b1, known_result(0, 0, 0, 0, 0, 0)};
    directed[1] = '{REQ_SAMPLE, 16'h1234, 9'd0, 16'h0, 1'b1,
                    known_result(16'h1234, 0, 0, 0, 0, 0)};
    directed[2] = '{REQ_SAMPLE, 16'hFFFF, 9'd1, 16'hFFFF, 1'b0, '0};
    directed[3] = '{REQ_SAMPLE, 16'hFFFF, 9'd511, 16'hFFFF, 1'b0, '0};
    directed[4] = '{REQ_SAMPLE, 16'h0, 9'd511, 16'h0, 1'b0, '0};
    directed[5] = '{REQ_SAMPLE, 16'h0100, 9'd60, 16'd100, 1'b0, '0};
    directed[6] = '{REQ_CLEAR, 16'hFFFF, 9'd511, 16'hFFFF, 1'b0, '0};
    directed[7] = '{REQ_SAMPLE, 16'h0200, 9'd0, 16'd500, 1'b0, '0};
    for (int i = 0; i < 16; i++)
      directed[8 + i] = '{REQ_SAMPLE, 16'(i * 4099), 9'(i * 31), 16'(i * 997), 1'b0, '0};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      row = directed[i];
      if (row.chk) begin
        got_exp = trip_predict(row.req, row.rate, row.spd, row.ms);
        if (got_exp !== row.exp) begin
          errors++;
          $display("table row %0d disagrees with predictor", i);
        end
        // Undo is unnecessary: these rows sit at reset, so re-run from reset.
        win_fill = 0; win_head = 0; rate_sum_m = 0; fpm_sum_m = 0; fpm_cnt_m = 0;
        fuel_m = 0; dist_m = 0; time_m = 0;
        if (i == 1) void'(trip_predict(REQ_CLEAR, 0, 0, 0));
      end
      send_item(row.req, row.rate, row.spd, row.ms);
    end
    wait_drained();

    // Long receiver hold-off while the sender keeps offering transactions.
    snk_hold = 1'b1;
    for (int i = 0; i < 10; i++) send_random();
    snk_hold = 1'b0;
    wait_drained();

    // Maximal samples back to back push the totals toward their largest values.
    for (int i = 0; i < 5; i++) send_item(REQ_SAMPLE, 16'hFFFF, 9'd511, 16'hFFFF);

    for (int p = 0; p < 4; p++) begin
      ph = idle_phase_t'(p);
      src_idle_pct = (ph == PH_SRC) ? 52 : (ph == PH_BOTH) ? 8 : 0;
      snk_idle_pct = (ph == PH_SNK) ? 52 : (ph == PH_BOTH) ? 8 : 0;
      for (int i = 0; i < 190; i++) send_random();
      wait_drained();
    end

    wait_drained();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // About 800 transactions, with stalls, taken many times over.
  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
